[rtl/per_disk_request_queues_with_purge_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-disk request queue block
// Concurrent checks on clk, disabled while rst is high; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PER_DISK_REQUEST_QUEUES_WITH_PURGE_UNIT_ASSERT_SVH
`define PER_DISK_REQUEST_QUEUES_WITH_PURGE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PDQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PDQ_ASSERT(lbl, prop, msg)
`define PDQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/pdq_pkg.sv]
// ----------------------------------------------------------------------------
// pdq_pkg
// Types, codes and default sizes shared by the per-disk request queue block.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int NUM_DISKS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int PID_W    = 16;
  localparam int CMD_W    = 2;
  localparam int DISK_W   = 3;
  localparam int COUNT_W  = 5;
  localparam int STAT_W   = 2;
  localparam int DIU_W    = 4;

  localparam logic [DIU_W-1:0] DISKS_IN_USE_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ     = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_PURGE    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PURGE,
    ST_EXEC
  } state_e;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_READ,
    LOP_COMPLETE,
    LOP_PSTART,
    LOP_PSTEP
  } lane_op_e;

  typedef struct packed {
    lane_op_e         op;
    logic [PID_W-1:0] pid;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DISK_W-1:0] disk;
    logic [PID_W-1:0]  process_id;
  } req_word_t;

  typedef struct packed {
    logic [PID_W-1:0]   served_id;
    logic [PID_W-1:0]   serving_now;
    logic [COUNT_W-1:0] waiting_count;
    logic [STAT_W-1:0]  status;
  } rsp_word_t;

endpackage

[rtl/per_disk_request_queues_with_purge_unit.sv]
// ----------------------------------------------------------------------------
// per_disk_request_queues_with_purge_unit
// Per-disk serving slots and order-keeping wait queues with purge by pid.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one command word: read request, completion or
//   purge of a process id. rsp (valid/ready) returns one word per command with
//   the served id, the addressed disk's slot and queue length, and a status.
//   cfg (valid/ready, always ready) writes disks_in_use; write it only while
//   no command is in flight.
// Sequence:
//   Read and complete go from idle through the execute state, which registers
//   the response word; the next command is taken only back in idle. A purge
//   walks every queue cell row in parallel, one cell per cycle, in the purge
//   state, then passes through execute for its response word. No new command
//   is taken until the last one is through. The row length sets how long the
//   purge walk lasts.
// Reset:
//   rst clears all slots and queue lengths and sets disks_in_use to 8.
// Stall:
//   The response sits in an output register; a new command is taken while it
//   waits only if it is being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "per_disk_request_queues_with_purge_unit_assert.svh"

module per_disk_request_queues_with_purge_unit
  import pdq_pkg::*;
#(
  parameter int NUM_DISKS   = NUM_DISKS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_word_t        req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_word_t        rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DIU_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  state_e           state;
  state_e           state_next;
  req_word_t        item;
  logic [DIU_W-1:0] disks_in_use;
  logic [LEN_W-1:0] purge_cnt;
  logic             accept;
  logic             disk_ok;

  lane_ctrl_t       lane_ctrl [NUM_DISKS];
  logic [PID_W-1:0] lane_slot [NUM_DISKS];
  logic [PID_W-1:0] lane_head [NUM_DISKS];
  logic [LEN_W-1:0] lane_len  [NUM_DISKS];

  logic [PID_W-1:0] sel_slot;
  logic [PID_W-1:0] sel_head;
  logic [LEN_W-1:0] sel_len;
  rsp_word_t        result;
  logic [LEN_W-1:0] res_len;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign disk_ok   = ({1'b0, item.disk} < disks_in_use) && (32'(item.disk) < NUM_DISKS);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.command == CMD_PURGE) ? ST_PURGE : ST_EXEC;
        end
      end
      ST_PURGE: begin
        if (purge_cnt == '0) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller: handshake and lane commands.
  always_comb begin
    req_ready = 1'b0;
    for (int d = 0; d < NUM_DISKS; d++) begin
      lane_ctrl[d].op  = LOP_NONE;
      lane_ctrl[d].pid = item.process_id;
    end
    case (state)
      ST_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        if (req_valid && (!rsp_valid || rsp_ready) && (req.command == CMD_PURGE)) begin
          for (int d = 0; d < NUM_DISKS; d++) begin
            lane_ctrl[d].op = LOP_PSTART;
          end
        end
      end
      ST_PURGE: begin
        for (int d = 0; d < NUM_DISKS; d++) begin
          lane_ctrl[d].op = LOP_PSTEP;
        end
      end
      ST_EXEC: begin
        for (int d = 0; d < NUM_DISKS; d++) begin
          if (disk_ok && (32'(item.disk) == d)) begin
            if ((item.command == CMD_READ) && (item.process_id != '0)) begin
              lane_ctrl[d].op = LOP_READ;
            end else if (item.command == CMD_COMPLETE) begin
              lane_ctrl[d].op = LOP_COMPLETE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Addressed disk's state before this command is applied.
  always_comb begin
    sel_slot = '0;
    sel_head = '0;
    sel_len  = '0;
    for (int d = 0; d < NUM_DISKS; d++) begin
      if (32'(item.disk) == d) begin
        sel_slot = lane_slot[d];
        sel_head = lane_head[d];
        sel_len  = lane_len[d];
      end
    end
  end

  // Response word: mirrors what the addressed lane does in the same cycle.
  always_comb begin
    result.served_id   = '0;
    result.serving_now = sel_slot;
    result.status      = STAT_OK;
    res_len            = sel_len;
    case (item.command)
      CMD_READ: begin
        if (!disk_ok || (item.process_id == '0)) begin
          result.status = STAT_BAD;
        end else if (sel_slot == '0) begin
          result.serving_now = item.process_id;
        end else if (sel_len < LEN_W'(QUEUE_DEPTH)) begin
          res_len = sel_len + 1'b1;
        end else begin
          result.status = STAT_FULL;
        end
      end
      CMD_COMPLETE: begin
        if (!disk_ok) begin
          result.status = STAT_BAD;
        end else begin
          result.served_id = sel_slot;
          if (sel_len != '0) begin
            result.serving_now = sel_head;
            res_len            = sel_len - 1'b1;
          end else begin
            result.serving_now = '0;
          end
        end
      end
      CMD_PURGE: begin
      end
      default: begin
        result.status = STAT_BAD;
      end
    endcase
    result.waiting_count = COUNT_W'(res_len);
    if (!disk_ok) begin
      result.serving_now   = '0;
      result.waiting_count = '0;
    end
  end

  for (genvar d = 0; d < NUM_DISKS; d++) begin : g_lane
    pdq_lane #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl[d]),
      .slot (lane_slot[d]),
      .head (lane_head[d]),
      .len  (lane_len[d])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      disks_in_use <= DISKS_IN_USE_RST;
      purge_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        disks_in_use <= cfg_data;
      end
      if (accept) begin
        purge_cnt <= LEN_W'(QUEUE_DEPTH - 1);
      end else if ((state == ST_PURGE) && (purge_cnt != '0)) begin
        purge_cnt <= purge_cnt - 1'b1;
      end
      if (state == ST_EXEC) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (state == ST_EXEC) begin
      rsp <= result;
    end
  end

  `PDQ_ASSERT_NEXT(a_accept_busy, accept, (state != ST_IDLE), "command taken but controller idle")
  `PDQ_ASSERT_NEXT(a_exec_word, (state == ST_EXEC), rsp_valid, "no response word after execute")
  `PDQ_ASSERT_NEXT(a_purge_end, ((state == ST_PURGE) && (purge_cnt == '0)), (state == ST_EXEC),
    "purge walk did not end in execute")

endmodule

[rtl/pdq_cell.sv]
// ----------------------------------------------------------------------------
// pdq_cell
// One queue entry: loads a new pid or takes its right neighbor's pid.
// ----------------------------------------------------------------------------
module pdq_cell
  import pdq_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [PID_W-1:0] load_data,
  input  logic             shift,
  input  logic [PID_W-1:0] shift_in,
  output logic [PID_W-1:0] data
);

  // A load wins over a shift: during a purge the tail cell takes the
  // recirculated head while the rest of the row moves toward the head.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_in;
    end
  end

endmodule

[rtl/pdq_lane.sv]
// ----------------------------------------------------------------------------
// pdq_lane
// One disk: serving slot, length counter and a row of queue cells, head first.
// ----------------------------------------------------------------------------
`include "per_disk_request_queues_with_purge_unit_assert.svh"

module pdq_lane
  import pdq_pkg::*;
#(
  parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctrl_t       ctrl,
  output logic [PID_W-1:0] slot,
  output logic [PID_W-1:0] head,
  output logic [LEN_W-1:0] len
);

  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] rem_next;
  logic [LEN_W-1:0] len_next;
  logic [PID_W-1:0] slot_next;
  logic             shift;
  logic             wr_en;
  logic [LEN_W-1:0] wr_pos;
  logic [PID_W-1:0] wr_data;
  logic [PID_W-1:0] cell_q [QUEUE_DEPTH];

  assign head = cell_q[0];

  always_comb begin
    slot_next = slot;
    len_next  = len;
    rem_next  = rem;
    shift     = 1'b0;
    wr_en     = 1'b0;
    wr_pos    = len;
    wr_data   = ctrl.pid;
    case (ctrl.op)
      LOP_READ: begin
        if (slot == '0) begin
          slot_next = ctrl.pid;
        end else if (len < LEN_W'(QUEUE_DEPTH)) begin
          wr_en    = 1'b1;
          len_next = len + 1'b1;
        end
      end
      LOP_COMPLETE: begin
        if (len != '0) begin
          slot_next = cell_q[0];
          shift     = 1'b1;
          len_next  = len - 1'b1;
        end else begin
          slot_next = '0;
        end
      end
      LOP_PSTART: begin
        rem_next = len;
      end
      LOP_PSTEP: begin
        // Pop the head each step; a survivor goes back in at the tail.
        if (rem != '0) begin
          shift    = 1'b1;
          rem_next = rem - 1'b1;
          if (cell_q[0] != ctrl.pid) begin
            wr_en   = 1'b1;
            wr_pos  = len - 1'b1;
            wr_data = cell_q[0];
          end else begin
            len_next = len - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PID_W-1:0] right;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_q[i+1];
    end
    pdq_cell u_cell (
      .clk       (clk),
      .load      (wr_en && (wr_pos == LEN_W'(i))),
      .load_data (wr_data),
      .shift     (shift),
      .shift_in  (right),
      .data      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      len  <= '0;
      rem  <= '0;
    end else begin
      slot <= slot_next;
      len  <= len_next;
      rem  <= rem_next;
    end
  end

  `PDQ_ASSERT(a_len_bound, (len <= LEN_W'(QUEUE_DEPTH)), "queue length above depth")
  `PDQ_ASSERT(a_rem_bound, (rem <= len), "purge walk count above queue length")
  `PDQ_ASSERT_NEXT(a_purge_shrinks, (ctrl.op == LOP_PSTEP), (len <= $past(len)),
    "purge step grew a queue")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives read, complete, purge and unused commands into the per-disk request
// queue block under random idling on both sides, and checks every response
// word against a queue-based prediction of the slots and wait lists.
// ----------------------------------------------------------------------------
module testbench;
  import pdq_pkg::*;

  localparam int NUM_DISKS   = NUM_DISKS_DEF;
  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int RUN_LIMIT   = 200000;

  logic             clk;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_word_t        req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_word_t        rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [DIU_W-1:0] cfg_data  = '0;

  per_disk_request_queues_with_purge_unit #(
    .NUM_DISKS  (NUM_DISKS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted disk state.
  logic [DIU_W-1:0] disks_active = DISKS_IN_USE_RST;
  logic [PID_W-1:0] slot_pid [NUM_DISKS] = '{default: '0};
  logic [PID_W-1:0] wait_list [NUM_DISKS][$];

  req_word_t cmd_backlog [$];
  rsp_word_t predicted_rsp [$];

  int  errors      = 0;
  int  cmds_taken  = 0;
  int  rsps_taken  = 0;
  int  drops_full  = 0;
  int  rejects     = 0;
  int  purges      = 0;
  int  cycles      = 0;
  int  send_gap    = 0;
  int  take_gap    = 0;
  bit  calm_send   = 1'b0;
  bit  calm_take   = 1'b0;

  // Applies one command to the predicted state and returns the response word.
  function automatic rsp_word_t schedule_disk_command(input req_word_t w);
    rsp_word_t        r;
    logic [PID_W-1:0] kept [$];
    logic             ok;
    int               d;
    int               k;
    int               j;
    r  = '0;
    d  = w.disk;
    ok = (d < disks_active) && (d < NUM_DISKS);
    case (w.command)
      CMD_READ: begin
        if (!ok || w.process_id == '0) begin
          r.status = STAT_BAD;
        end else if (slot_pid[d] == '0) begin
          slot_pid[d] = w.process_id;
        end else if (wait_list[d].size() < QUEUE_DEPTH) begin
          wait_list[d] = {wait_list[d], w.process_id};
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_COMPLETE: begin
        if (!ok) begin
          r.status = STAT_BAD;
        end else begin
          r.served_id = slot_pid[d];
          slot_pid[d] = '0;
          if (wait_list[d].size() != 0) begin
            slot_pid[d] = wait_list[d][0];
            wait_list[d].delete(0);
          end
        end
      end
      CMD_PURGE: begin
        // Every disk is purged, whatever disk number the word carries.
        purges++;
        for (k = 0; k < NUM_DISKS; k++) begin
          kept = {};
          for (j = 0; j < wait_list[k].size(); j++) begin
            if (wait_list[k][j] != w.process_id) begin
              kept = {kept, wait_list[k][j]};
            end
          end
          wait_list[k] = kept;
        end
      end
      default: begin
        r.status = STAT_BAD;
      end
    endcase
    if (ok) begin
      r.serving_now   = slot_pid[d];
      r.waiting_count = COUNT_W'(wait_list[d].size());
    end
    if (r.status == STAT_FULL) begin
      drops_full++;
    end
    if (r.status == STAT_BAD) begin
      rejects++;
    end
    return r;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req_valid && req_ready) begin
        predicted_rsp = {predicted_rsp, schedule_disk_command(req)};
        cmds_taken++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          req       <= cmd_backlog[0];
          cmd_backlog.delete(0);
          req_valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) calm_send = !calm_send;
          send_gap  <= calm_send ? 0 : $urandom_range(0, 6);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin : take_rsp
    int        hold;
    rsp_word_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      take_gap  <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsps_taken++;
        if (predicted_rsp.size() == 0) begin
          errors++;
          $display("%0t: response word with none expected, expected nothing, actual %h",
                   $time, rsp);
        end else begin
          want = predicted_rsp[0];
          predicted_rsp.delete(0);
          check_field("served_id", want.served_id, rsp.served_id);
          check_field("serving_now", want.serving_now, rsp.serving_now);
          check_field("waiting_count", want.waiting_count, rsp.waiting_count);
          check_field("status", want.status, rsp.status);
        end
        if ($urandom_range(0, 29) == 0) calm_take = !calm_take;
        hold = calm_take ? 0 : $urandom_range(0, 6);
        take_gap  <= hold;
        rsp_ready <= (hold == 0);
      end else if (take_gap != 0) begin
        take_gap  <= take_gap - 1;
        rsp_ready <= (take_gap == 1);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_e c, input int d, input logic [PID_W-1:0] pid);
    req_word_t w;
    w.command    = c;
    w.disk       = DISK_W'(d);
    w.process_id = pid;
    cmd_backlog = {cmd_backlog, w};
  endtask

  // Mostly disks inside the active range, so that the queues actually fill.
  function automatic int pick_disk();
    int lim;
    lim = (disks_active < NUM_DISKS) ? int'(disks_active) : NUM_DISKS;
    if (lim != 0 && $urandom_range(0, 3) != 0) begin
      return $urandom_range(0, lim - 1);
    end
    return $urandom_range(0, NUM_DISKS - 1);
  endfunction

  // A small pool of pids makes purges hit queued entries.
  function automatic logic [PID_W-1:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return PID_W'($urandom_range(1, 8));
    if (r < 72) return '0;
    return PID_W'($urandom);
  endfunction

  task automatic queue_random(input int count);
    int   left;
    int   n;
    int   d;
    int   r;
    cmd_e c;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        // Burst of reads on one disk to drive its queue to full.
        d = pick_disk();
        n = $urandom_range(12, 20);
        while (n > 0 && left > 0) begin
          push_cmd(CMD_READ, d, PID_W'($urandom_range(1, 8)));
          n--;
          left--;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) c = CMD_READ;
        else if (r < 82) c = CMD_COMPLETE;
        else if (r < 94) c = CMD_PURGE;
        else c = CMD_NONE;
        push_cmd(c, pick_disk(), pick_pid());
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0);
  endtask

  task automatic write_disks_in_use(input logic [DIU_W-1:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    disks_active = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [DIU_W-1:0] settings [4];
    int               i;
    settings = '{4'd1, 4'd15, 4'd3, 4'd8};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill disk 7 to the brim, then one more read is dropped.
    push_cmd(CMD_READ, 7, 16'hFFFF);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      push_cmd(CMD_READ, 7, (i % 2 == 0) ? 16'h0001 : 16'hA5A5);
    end
    push_cmd(CMD_READ, 7, 16'h5A5A);
    // Purge pulls every pid 1 out of the middle of the queue.
    push_cmd(CMD_PURGE, 7, 16'h0001);
    push_cmd(CMD_COMPLETE, 7, 16'h0000);
    push_cmd(CMD_READ, 0, 16'h0000);
    push_cmd(CMD_COMPLETE, 0, 16'hFFFF);
    push_cmd(CMD_NONE, 3, 16'h0003);
    push_cmd(CMD_PURGE, 0, 16'h0000);
    push_cmd(CMD_READ, 0, 16'h8000);
    queue_random(150);
    wait_drained();

    for (i = 0; i < 4; i++) begin
      write_disks_in_use(settings[i]);
      queue_random(75);
      wait_drained();
    end

    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    $display("%0d commands and %0d responses over disks_in_use 8, 1, 15, 3, 8",
             cmds_taken, rsps_taken);
    $display("%0d reads dropped on a full queue, %0d words rejected, %0d purges",
             drops_full, rejects, purges);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[per_disk_request_queues_with_purge_unit.f]
+incdir+rtl
rtl/pdq_pkg.sv
rtl/pdq_cell.sv
rtl/pdq_lane.sv
rtl/per_disk_request_queues_with_purge_unit.sv
tb/testbench.sv
